/* sv/abd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

    // Baud rate codes on the result channel
    localparam logic [1:0] BAUD_1200 = 2'd0;
    localparam logic [1:0] BAUD_2400 = 2'd1;
    localparam logic [1:0] BAUD_4800 = 2'd2;
    localparam logic [1:0] BAUD_9600 = 2'd3;

    localparam int unsigned CODE_W    = 2;
    localparam int unsigned MIN_W     = 16;
    localparam int unsigned CLS_W     = 32;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CNT_W-1:0] EDGES_RESET = 8'd100;

    // Open classification windows, in ticks
    localparam logic [CLS_W-1:0] W1200_LO = 32'd820;
    localparam logic [CLS_W-1:0] W1200_HI = 32'd850;
    localparam logic [CLS_W-1:0] W2400_LO = 32'd400;
    localparam logic [CLS_W-1:0] W2400_HI = 32'd430;
    localparam logic [CLS_W-1:0] W4800_LO = 32'd190;
    localparam logic [CLS_W-1:0] W4800_HI = 32'd220;
    localparam logic [CLS_W-1:0] W9600_LO = 32'd90;
    localparam logic [CLS_W-1:0] W9600_HI = 32'd120;

    typedef struct packed {
        logic valid;
        logic kind;
    } abd_ctl_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              hit;
    } abd_cls_t;

    function automatic abd_cls_t abd_classify(input logic [CLS_W-1:0] g);
        abd_cls_t r;
        r.hit = 1'b1;
        if (g > W1200_LO && g < W1200_HI) begin
            r.code = BAUD_1200;
        end else if (g > W2400_LO && g < W2400_HI) begin
            r.code = BAUD_2400;
        end else if (g > W4800_LO && g < W4800_HI) begin
            r.code = BAUD_4800;
        end else if (g > W9600_LO && g < W9600_HI) begin
            r.code = BAUD_9600;
        end else begin
            r.code = BAUD_2400;
            r.hit  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/abd_input_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module abd_input_stage #(
    parameter int unsigned STAMP_BITS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_kind,
    input  wire  [STAMP_BITS-1:0]      s_stamp,
    input  wire                        advance,
    output abd_pkg::abd_ctl_t          ctl,
    output logic [STAMP_BITS-1:0]      stamp
);
    import abd_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  kind_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic                  load;

    // Take a new transaction whenever the held one leaves or none is held
    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= s_kind;
            stamp_reg <= s_stamp;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.kind  = kind_reg;
    assign stamp     = stamp_reg;

endmodule

`default_nettype wire

/* sv/abd_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module abd_core #(
    parameter int unsigned STAMP_BITS = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire  [abd_pkg::CNT_W-1:0]         edges_cfg,
    input  wire  abd_pkg::abd_ctl_t           ctl,
    input  wire  [STAMP_BITS-1:0]             stamp,
    output logic                              advance,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [abd_pkg::CODE_W-1:0]        m_code,
    output logic                              m_hit,
    output logic [abd_pkg::MIN_W-1:0]         m_min
);
    import abd_pkg::*;

    logic [STAMP_BITS-1:0] last_stamp_reg, last_stamp_next;
    logic                  have_last_reg, have_last_next;
    logic [STAMP_BITS-1:0] smallest_reg, smallest_next;
    logic [CNT_W-1:0]      edges_left_reg, edges_left_next;
    logic                  finished_reg, finished_next;
    logic                  res_valid_reg, res_valid_next;
    logic [CODE_W-1:0]     res_code_reg;
    logic                  res_hit_reg;
    logic [MIN_W-1:0]      res_min_reg;

    logic [STAMP_BITS-1:0] gap;
    logic                  decides;
    logic                  fire;
    logic                  emit;
    abd_cls_t              cls;

    assign gap     = stamp - last_stamp_reg;
    assign decides = ctl.valid && !ctl.kind && !finished_reg && (edges_left_reg <= 8'd1);
    // Only a deciding edge needs room in the result register
    assign advance = !decides || !res_valid_reg || m_ready;
    assign fire    = ctl.valid && advance;
    assign emit    = fire && decides;

    always_comb begin
        last_stamp_next = last_stamp_reg;
        have_last_next  = have_last_reg;
        smallest_next   = smallest_reg;
        edges_left_next = edges_left_reg;
        finished_next   = finished_reg;
        if (fire) begin
            if (ctl.kind) begin
                last_stamp_next = '0;
                have_last_next  = 1'b0;
                smallest_next   = '1;
                edges_left_next = edges_cfg;
                finished_next   = 1'b0;
            end else if (!finished_reg) begin
                if (have_last_reg && (gap < smallest_reg)) begin
                    smallest_next = gap;
                end
                last_stamp_next = stamp;
                have_last_next  = 1'b1;
                if (edges_left_reg > 8'd1) begin
                    edges_left_next = edges_left_reg - 8'd1;
                end else begin
                    edges_left_next = '0;
                    finished_next   = 1'b1;
                end
            end
        end
    end

    assign cls = abd_classify(CLS_W'(smallest_next));

    always_comb begin
        res_valid_next = res_valid_reg;
        if (m_ready) begin
            res_valid_next = 1'b0;
        end
        if (emit) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg <= '0;
            have_last_reg  <= 1'b0;
            smallest_reg   <= '1;
            edges_left_reg <= EDGES_RESET;
            finished_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            last_stamp_reg <= last_stamp_next;
            have_last_reg  <= have_last_next;
            smallest_reg   <= smallest_next;
            edges_left_reg <= edges_left_next;
            finished_reg   <= finished_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_code_reg <= cls.code;
            res_hit_reg  <= cls.hit;
            res_min_reg  <= MIN_W'(smallest_next);
        end
    end

    assign m_valid = res_valid_reg;
    assign m_code  = res_code_reg;
    assign m_hit   = res_hit_reg;
    assign m_min   = res_min_reg;

    a_emit_sets_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> finished_reg && res_valid_reg)
        else $error("deciding edge did not leave a pending result");

    a_finished_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> edges_left_reg == '0)
        else $error("countdown nonzero after decision");

    a_late_edge_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !ctl.kind && finished_reg |=> $stable(smallest_reg) && $stable(last_stamp_reg))
        else $error("edge after decision changed state");

endmodule

`default_nettype wire

/* sv/autobaud_min_bit_time_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// --------  ---------  -----------------------------------------------------
// s_axis    in         tuser = kind (0 edge, 1 restart); tdata = edge_time
// m_axis    out        tdata = baud_code, window_matched, min_interval
// cfg       in         cfg_wr_data = edges_to_observe, written on cfg_wr_en
//
// One transaction per cycle in each direction unless m_axis stalls; an item
// passes the input register, then the state update into the result register.
// Reset is synchronous, active low; it loads edges_to_observe with 100 and
// clears the run state. A stalled m_axis holds only a deciding edge; edges
// and restarts that give no result keep flowing past a waiting result.
module autobaud_min_bit_time_detector #(
    parameter int unsigned STAMP_BITS = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Stream in
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [STAMP_BITS-1:0] edge_time, upper bits zero padding
    input  wire  [((STAMP_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // [0] kind
    input  wire                               s_axis_tuser,
    // Stream out
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [1:0] baud_code, [2] window_matched, [18:3] min_interval, [23:19] zero
    output logic [abd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Configuration
    input  wire                               cfg_wr_en,
    input  wire  [abd_pkg::CNT_W-1:0]         cfg_wr_data
);
    import abd_pkg::*;

    logic [CNT_W-1:0]      edges_cfg_reg, edges_cfg_next;
    logic                  advance;
    abd_ctl_t              ctl;
    logic [STAMP_BITS-1:0] stamp;
    logic [CODE_W-1:0]     code;
    logic                  hit;
    logic [MIN_W-1:0]      min_gap;

    // Hold the countdown reload value; it takes effect on the next restart
    always_comb begin
        edges_cfg_next = edges_cfg_reg;
        if (cfg_wr_en) begin
            edges_cfg_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edges_cfg_reg <= EDGES_RESET;
        end else begin
            edges_cfg_reg <= edges_cfg_next;
        end
    end

    // Register the incoming transaction
    abd_input_stage #(
        .STAMP_BITS(STAMP_BITS)
    ) u_input (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_kind  (s_axis_tuser),
        .s_stamp (s_axis_tdata[STAMP_BITS-1:0]),
        .advance (advance),
        .ctl     (ctl),
        .stamp   (stamp)
    );

    // Update gap tracking and countdown, classify, register the result
    abd_core #(
        .STAMP_BITS(STAMP_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edges_cfg (edges_cfg_reg),
        .ctl       (ctl),
        .stamp     (stamp),
        .advance   (advance),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_code    (code),
        .m_hit     (hit),
        .m_min     (min_gap)
    );

    assign m_axis_tdata = {5'd0, min_gap, hit, code};

endmodule

`default_nettype wire

/* tb/tb_autobaud_min_bit_time_detector.sv */
`timescale 1ns / 1ps

module tb_autobaud_min_bit_time_detector;

    import abd_pkg::*;

    // Kind codes carried on s_axis_tuser
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int unsigned TARGET_ITEMS  = 750;
    localparam int unsigned MIN_DECISIONS = 40;
    localparam int unsigned SETTLE_CYCLES = 8;    // two-stage pipe plus margin
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // One baud decision, holding the fields carried on m_axis_tdata
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              hit;
        logic [MIN_W-1:0]  gap;
    } baud_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] edge_time
    logic        s_axis_tuser  = 1'b0;  // [0] kind
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_axis_tdata; // [1:0] baud_code, [2] window_matched,
                                        // [18:3] min_interval
    logic        cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;

    // Predictor state, a private copy of what the block keeps
    logic [CNT_W-1:0] edges_cfg       = EDGES_RESET;
    logic [15:0]      prev_stamp      = '0;
    logic             have_prev       = 1'b0;
    logic [15:0]      smallest_gap    = 16'hFFFF;
    logic [CNT_W-1:0] edges_remaining = EDGES_RESET;
    logic             run_done        = 1'b0;

    baud_result_t pending_bauds[$];
    baud_result_t check_want;

    // Sender and receiver shaping
    bit          offering   = 1'b0;
    bit          idle_on    = 1'b1;
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;
    logic [1:0]  rx_mode    = 2'd0;
    logic [5:0]  rx_tick    = '0;
    logic        rx_want;

    int unsigned errors              = 0;
    int unsigned items_sent          = 0;
    int unsigned decisions_predicted = 0;
    int unsigned decisions_checked   = 0;
    int unsigned windows_hit         = 0;
    int unsigned cfg_writes          = 0;

    autobaud_min_bit_time_detector #(
        .STAMP_BITS (16)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Map a gap onto the open baud windows; fall back to 2400 unmatched.
    function automatic baud_result_t classify_gap(input logic [15:0] gap);
        baud_result_t r;
        logic [CLS_W-1:0] g;
        g     = {{(CLS_W-16){1'b0}}, gap};
        r.gap = gap;
        r.hit = 1'b1;
        if (g > W1200_LO && g < W1200_HI) begin
            r.code = BAUD_1200;
        end else if (g > W2400_LO && g < W2400_HI) begin
            r.code = BAUD_2400;
        end else if (g > W4800_LO && g < W4800_HI) begin
            r.code = BAUD_4800;
        end else if (g > W9600_LO && g < W9600_HI) begin
            r.code = BAUD_9600;
        end else begin
            r.code = BAUD_2400;
            r.hit  = 1'b0;
        end
        return r;
    endfunction

    // Advance the predicted state by one accepted transaction.
    task automatic predict_baud(input logic kind, input logic [15:0] stamp);
        logic [15:0]  gap;
        baud_result_t res;
        if (kind == KIND_RESTART) begin
            // Clear the run and reload the countdown from the register
            prev_stamp      = '0;
            have_prev       = 1'b0;
            smallest_gap    = 16'hFFFF;
            edges_remaining = edges_cfg;
            run_done        = 1'b0;
        end else if (!run_done) begin
            if (have_prev) begin
                gap = stamp - prev_stamp;   // wraps modulo 2^16
                if (gap < smallest_gap) begin
                    smallest_gap = gap;
                end
            end
            prev_stamp = stamp;
            have_prev  = 1'b1;
            if (edges_remaining > 1) begin
                edges_remaining = edges_remaining - 8'd1;
            end else begin
                // A zero countdown decides on the next edge, like a one
                edges_remaining = '0;
                run_done        = 1'b1;
                res             = classify_gap(smallest_gap);
                pending_bauds.push_back(res);
                decisions_predicted++;
                if (res.hit) begin
                    windows_hit++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until the block takes it. Valid stays
    // high on return so that a back-to-back item needs no second assignment.
    task automatic send_item(input logic kind, input logic [15:0] stamp);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= stamp;
        offering = 1'b1;
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) begin
            @(posedge aclk);
        end
        items_sent++;
        predict_baud(kind, stamp);
    endtask

    // Drop valid and scramble the payload the block must ignore.
    task automatic stop_offer();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            s_axis_tdata  <= 16'($urandom_range(0, 65535));
            offering = 1'b0;
        end
    endtask

    // Send in bursts of random length, with random gaps between them.
    task automatic offer(input logic kind, input logic [15:0] stamp);
        int unsigned gap_len;
        if (burst_left == 0) begin
            gap_len    = idle_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap_len != 0) begin
                stop_offer();
                repeat (gap_len) @(posedge aclk);
            end
        end
        burst_left--;
        send_item(kind, stamp);
    endtask

    // Pause the sender until every expected decision has arrived, then let
    // the pipe empty of items that cause no result.
    task automatic drain();
        stop_offer();
        while (pending_bauds.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the edge-count register while the block is idle.
    task automatic write_edges_cfg(input logic [CNT_W-1:0] value);
        drain();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        edges_cfg = value;
        cfg_writes++;
    endtask

    // Pick the smallest gap a run aims for: window interiors, the open
    // bounds themselves, zero, and anything else the 16 bits allow.
    function automatic logic [15:0] pick_floor();
        logic [15:0] lo;
        logic [15:0] hi;
        case ($urandom_range(0, 3))
            0:       begin lo = W1200_LO[15:0]; hi = W1200_HI[15:0]; end
            1:       begin lo = W2400_LO[15:0]; hi = W2400_HI[15:0]; end
            2:       begin lo = W4800_LO[15:0]; hi = W4800_HI[15:0]; end
            default: begin lo = W9600_LO[15:0]; hi = W9600_HI[15:0]; end
        endcase
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: pick_floor = 16'($urandom_range(lo + 1, hi - 1));
            5:             pick_floor = lo;
            6:             pick_floor = hi;
            7:             pick_floor = $urandom_range(0, 1) ? lo + 16'd1 : hi - 16'd1;
            8:             pick_floor = 16'd0;
            9:             pick_floor = 16'($urandom_range(0, 1000));
            10:            pick_floor = 16'($urandom_range(0, 65535));
            default:       pick_floor = 16'hFFFF;
        endcase
    endfunction

    // Drive one run of edges whose gaps sit at or above a chosen floor, then
    // up to two stray edges, past the decision unless a restart cut the run.
    task automatic drive_run(input int unsigned n_edges, input bit noisy);
        logic [15:0] floor_gap;
        logic [15:0] stamp;
        int unsigned spread;
        int unsigned gap;
        floor_gap = pick_floor();
        stamp     = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 40;
            2:       spread = 2000;
            default: spread = 65535;
        endcase
        for (int unsigned i = 0; i < n_edges; i++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                offer(KIND_RESTART, 16'($urandom_range(0, 65535)));
            end
            gap = floor_gap;
            if ($urandom_range(0, 3) != 0) begin
                gap = gap + $urandom_range(0, spread);
                if (gap > 65535) begin
                    gap = 65535;
                end
            end
            stamp = stamp + 16'(gap);
            offer(KIND_EDGE, stamp);
        end
        repeat ($urandom_range(0, 2)) begin
            stamp = stamp + 16'($urandom_range(0, 900));
            offer(KIND_EDGE, stamp);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == '0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0:    rx_want = 1'b1;
            2'd1:    rx_want = ($urandom_range(0, 3) != 0);
            2'd2:    rx_want = ($urandom_range(0, 3) == 0);
            default: rx_want = (rx_tick[2:0] != 3'd0);
        endcase
        m_axis_tready <= rx_want && (hold_left == 0);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        errors++;
    endtask

    // Compare each accepted decision with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_bauds.size() == 0) begin
                report_mismatch("unexpected decision", 0, 32'(m_axis_tdata));
            end else begin
                check_want = pending_bauds.pop_front();
                decisions_checked++;
                if (m_axis_tdata[1:0] !== check_want.code) begin
                    report_mismatch("baud_code", 32'(check_want.code),
                                    32'(m_axis_tdata[1:0]));
                end
                if (m_axis_tdata[2] !== check_want.hit) begin
                    report_mismatch("window_matched", 32'(check_want.hit),
                                    32'(m_axis_tdata[2]));
                end
                if (m_axis_tdata[18:3] !== check_want.gap) begin
                    report_mismatch("min_interval", 32'(check_want.gap),
                                    32'(m_axis_tdata[18:3]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run the countdown loaded at reset, without any register write.
    task automatic test_reset_countdown();
        drive_run(EDGES_RESET, 1'b0);
    endtask

    // A lone edge measures no interval: all ones, unmatched default.
    task automatic test_single_edge();
        write_edges_cfg(8'd1);
        send_item(KIND_RESTART, 16'h0000);
        send_item(KIND_EDGE, 16'hFFFF);
    endtask

    // Edges that share a stamp give a zero interval.
    task automatic test_equal_stamps();
        write_edges_cfg(8'd2);
        send_item(KIND_RESTART, 16'hFFFF);
        send_item(KIND_EDGE, 16'h0000);
        send_item(KIND_EDGE, 16'h0000);
    endtask

    // Hit the middle of every window, each pair wrapping the tick counter.
    task automatic test_each_window();
        logic [15:0] mids[4];
        mids = '{16'd835, 16'd415, 16'd205, 16'd105};
        foreach (mids[i]) begin
            send_item(KIND_RESTART, 16'h1234);
            send_item(KIND_EDGE, 16'hFFF0);
            send_item(KIND_EDGE, 16'hFFF0 + mids[i]);
        end
    endtask

    // A zero countdown decides on the next edge; later edges are ignored.
    task automatic test_zero_countdown();
        write_edges_cfg(8'd0);
        send_item(KIND_RESTART, 16'h0000);
        send_item(KIND_EDGE, 16'h5A5A);
        send_item(KIND_EDGE, 16'h5A5A + 16'd105);
        send_item(KIND_EDGE, 16'h5A5A + 16'd210);
    endtask

    // Hold the receiver off while one-edge runs keep coming, so decisions
    // pile up and the block stalls its input; then pause until all drain.
    task automatic test_backpressure();
        logic [15:0] stamp;
        write_edges_cfg(8'd1);
        hold_left <= HOLD_CYCLES;
        stamp = 16'($urandom_range(0, 65535));
        repeat (16) begin
            send_item(KIND_RESTART, 16'($urandom_range(0, 65535)));
            send_item(KIND_EDGE, stamp);
            stamp = stamp + 16'd1;
        end
        drain();
    endtask

    // Random phases: new register value, then well-formed runs with random
    // content, some of them broken up by restarts.
    task automatic test_random_runs();
        logic [CNT_W-1:0] count;
        while (items_sent < TARGET_ITEMS || decisions_predicted < MIN_DECISIONS) begin
            case ($urandom_range(0, 19))
                0:       count = 8'd0;
                1:       count = 8'd255;
                2, 3:    count = 8'($urandom_range(9, 60));
                default: count = 8'($urandom_range(1, 8));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            write_edges_cfg(count);
            repeat ((count == 8'd255) ? 1 : $urandom_range(1, 3)) begin
                offer(KIND_RESTART, 16'($urandom_range(0, 65535)));
                drive_run((count == 0) ? 1 : count, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_countdown();
        test_single_edge();
        test_equal_stamps();
        test_each_window();
        test_zero_countdown();
        test_backpressure();
        test_random_runs();

        drain();
        if (pending_bauds.size() != 0) begin
            report_mismatch("decisions never seen", 0, pending_bauds.size());
        end
        $display("Covered %0d input transactions and %0d register writes,",
                 items_sent, cfg_writes);
        $display("checking %0d baud decisions (%0d inside a window).",
                 decisions_checked, windows_hit);
        if (errors == 0) begin
            $display("tb_autobaud_min_bit_time_detector: PASS");
        end else begin
            $display("tb_autobaud_min_bit_time_detector: FAIL");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_autobaud_min_bit_time_detector: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/abd_pkg.sv
sv/abd_input_stage.sv
sv/abd_core.sv
sv/autobaud_min_bit_time_detector.sv
tb/tb_autobaud_min_bit_time_detector.sv
